@@ rtl/ehp_pkg.sv @@
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
package ehp_pkg;

  localparam logic [15:0] MAX_FRAME_BYTES  = 16'hFFFF;
  localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
  localparam logic [5:0]  MIN_IP_HDR_BYTES = 6'd20;
  localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;
  localparam logic [5:0]  MIN_TCP_HDR_BYTES = 6'd20;
  // TCP header must reach the flags byte before the offset is trusted
  localparam logic [15:0] TCP_FLAGS_END    = 16'd14;
  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_ARP        = 16'h0806;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_IP      = 3'd1,
    ST_BAD_UDP_LEN = 3'd2,
    ST_BAD_TCP_OFF = 3'd3,
    ST_TRUNC       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_ARP   = 2'd1,
    CLS_IPV4  = 2'd2
  } frame_class_t;

  // Everything captured from one frame, handed from front to back.
  typedef struct packed {
    logic [15:0]  frame_len;
    frame_class_t frame_class;
    logic [47:0]  dest_mac;
    logic [47:0]  src_mac;
    logic [3:0]   ip_words;
    logic [7:0]   protocol;
    logic [31:0]  src_ip;
    logic [31:0]  dest_ip;
    logic [15:0]  src_port;
    logic [15:0]  dest_port;
    logic [15:0]  udp_length;
    logic [3:0]   tcp_words;
    logic [7:0]   tcp_flags;
    logic [31:0]  tcp_sequence;
  } frame_rec_t;

  // Queue side status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ rtl/ehp_front.sv @@
// Byte front end: frame position counter and header field capture.
module ehp_front import ehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  queue_stat_t q_stat,
  output logic        push,
  output frame_rec_t  push_rec
);

  logic [15:0] idx_r;
  logic [47:0] dmac_r, dmac_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] dip_r, dip_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] ulen_r, ulen_nxt;
  logic [3:0]  toff_r, toff_nxt;
  logic [7:0]  tflags_r, tflags_nxt;
  logic [31:0] tseq_r, tseq_nxt;

  logic        accept;
  logic        cap_en;
  logic [15:0] l4_start;
  logic        l4_hit;
  logic [15:0] rel;
  logic [15:0] frame_len;
  frame_class_t cls;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign cap_en   = (idx_r != MAX_FRAME_BYTES);

  // L4 header starts after Ethernet + IHL words
  assign l4_start = ETH_HDR_BYTES + {10'd0, ihl_r, 2'b00};
  assign l4_hit   = ({ihl_r, 2'b00} >= MIN_IP_HDR_BYTES) && (idx_r >= l4_start);
  assign rel      = idx_r - l4_start;

  always_comb begin
    dmac_nxt   = dmac_r;
    smac_nxt   = smac_r;
    etype_nxt  = etype_r;
    ihl_nxt    = ihl_r;
    proto_nxt  = proto_r;
    sip_nxt    = sip_r;
    dip_nxt    = dip_r;
    sport_nxt  = sport_r;
    dport_nxt  = dport_r;
    ulen_nxt   = ulen_r;
    toff_nxt   = toff_r;
    tflags_nxt = tflags_r;
    tseq_nxt   = tseq_r;
    if (cap_en) begin
      if (idx_r < 16'd6) begin
        dmac_nxt = {dmac_r[39:0], in_data_byte};
      end else if (idx_r < 16'd12) begin
        smac_nxt = {smac_r[39:0], in_data_byte};
      end else if (idx_r < ETH_HDR_BYTES) begin
        etype_nxt = {etype_r[7:0], in_data_byte};
      end
      if (idx_r == 16'd14) ihl_nxt = in_data_byte[3:0];
      if (idx_r == 16'd23) proto_nxt = in_data_byte;
      if (idx_r >= 16'd26 && idx_r <= 16'd29) sip_nxt = {sip_r[23:0], in_data_byte};
      if (idx_r >= 16'd30 && idx_r <= 16'd33) dip_nxt = {dip_r[23:0], in_data_byte};
      if (l4_hit) begin
        if (rel < 16'd2) begin
          sport_nxt = {sport_r[7:0], in_data_byte};
        end else if (rel < 16'd4) begin
          dport_nxt = {dport_r[7:0], in_data_byte};
        end
        if (rel == 16'd4 || rel == 16'd5) ulen_nxt = {ulen_r[7:0], in_data_byte};
        if (rel >= 16'd4 && rel <= 16'd7) tseq_nxt = {tseq_r[23:0], in_data_byte};
        if (rel == 16'd12) toff_nxt = in_data_byte[7:4];
        if (rel == 16'd13) tflags_nxt = in_data_byte;
      end
    end
  end

  // length saturates once the counter parks at the max
  assign frame_len = cap_en ? (idx_r + 16'd1) : MAX_FRAME_BYTES;

  always_comb begin
    if (frame_len < ETH_HDR_BYTES) begin
      cls = CLS_OTHER;
    end else if (etype_nxt == ETYPE_IPV4) begin
      cls = CLS_IPV4;
    end else if (etype_nxt == ETYPE_ARP) begin
      cls = CLS_ARP;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign push = accept && in_last_byte;

  always_comb begin
    push_rec.frame_len    = frame_len;
    push_rec.frame_class  = cls;
    push_rec.dest_mac     = dmac_nxt;
    push_rec.src_mac      = smac_nxt;
    push_rec.ip_words     = ihl_nxt;
    push_rec.protocol     = proto_nxt;
    push_rec.src_ip       = sip_nxt;
    push_rec.dest_ip      = dip_nxt;
    push_rec.src_port     = sport_nxt;
    push_rec.dest_port    = dport_nxt;
    push_rec.udp_length   = ulen_nxt;
    push_rec.tcp_words    = toff_nxt;
    push_rec.tcp_flags    = tflags_nxt;
    push_rec.tcp_sequence = tseq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      idx_r    <= '0;
      dmac_r   <= '0;
      smac_r   <= '0;
      etype_r  <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      sip_r    <= '0;
      dip_r    <= '0;
      sport_r  <= '0;
      dport_r  <= '0;
      ulen_r   <= '0;
      toff_r   <= '0;
      tflags_r <= '0;
      tseq_r   <= '0;
    end else if (accept) begin
      if (cap_en) idx_r <= idx_r + 16'd1;
      dmac_r   <= dmac_nxt;
      smac_r   <= smac_nxt;
      etype_r  <= etype_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      sip_r    <= sip_nxt;
      dip_r    <= dip_nxt;
      sport_r  <= sport_nxt;
      dport_r  <= dport_nxt;
      ulen_r   <= ulen_nxt;
      toff_r   <= toff_nxt;
      tflags_r <= tflags_nxt;
      tseq_r   <= tseq_nxt;
    end
  end

endmodule

@@ rtl/ehp_queue.sv @@
// Two-entry record queue between front and back.
module ehp_queue import ehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_rec_t  push_rec,
  input  logic        pop,
  output frame_rec_t  head_rec,
  output queue_stat_t q_stat
);

  frame_rec_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign head_rec     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/ehp_back.sv @@
// Back end: header checks, payload length and the output register.
module ehp_back import ehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frame_rec_t  head_rec,
  input  queue_stat_t q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_frame_class,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_src_mac,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dest_ip,
  output logic [7:0]  out_ip_protocol,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dest_port,
  output logic [7:0]  out_tcp_flag_bits,
  output logic [31:0] out_tcp_sequence,
  output logic [15:0] out_payload_len
);

  logic        valid_r;
  logic [2:0]  status_r;
  logic [1:0]  class_r;
  logic [47:0] dmac_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] dip_r;
  logic [7:0]  proto_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [7:0]  flags_r;
  logic [31:0] seq_r;
  logic [15:0] pay_r;
  status_t     st;
  logic [15:0] pay;
  logic        ports;
  logic        tcp;
  logic        is_ip;
  logic [15:0] ip_end;
  logic [15:0] tcp_hdr;
  logic [15:0] len;

  assign len     = head_rec.frame_len;
  assign is_ip   = (head_rec.frame_class == CLS_IPV4);
  assign ip_end  = ETH_HDR_BYTES + {10'd0, head_rec.ip_words, 2'b00};
  assign tcp_hdr = {10'd0, head_rec.tcp_words, 2'b00};

  always_comb begin
    st    = ST_OK;
    pay   = '0;
    ports = 1'b0;
    tcp   = 1'b0;
    if (len < ETH_HDR_BYTES) st = ST_TRUNC;
    if (is_ip) begin
      if (len < ETH_HDR_BYTES + 16'd1) begin
        st = ST_TRUNC;
      end else if ({head_rec.ip_words, 2'b00} < MIN_IP_HDR_BYTES) begin
        st = ST_BAD_IP;
      end else if (len < ip_end) begin
        st = ST_TRUNC;
      end else if (head_rec.protocol == PROTO_UDP) begin
        if (len < ip_end + UDP_HDR_BYTES) begin
          st = ST_TRUNC;
        end else if (head_rec.udp_length < UDP_HDR_BYTES) begin
          st = ST_BAD_UDP_LEN;
        end else begin
          pay   = len - ip_end - UDP_HDR_BYTES;
          ports = 1'b1;
        end
      end else if (head_rec.protocol == PROTO_TCP) begin
        if (len < ip_end + TCP_FLAGS_END) begin
          st = ST_TRUNC;
        end else if ({head_rec.tcp_words, 2'b00} < MIN_TCP_HDR_BYTES) begin
          st = ST_BAD_TCP_OFF;
        end else if (len < ip_end + tcp_hdr) begin
          st = ST_TRUNC;
        end else begin
          pay   = len - ip_end - tcp_hdr;
          ports = 1'b1;
          tcp   = 1'b1;
        end
      end
    end
  end

  assign pop       = !q_stat.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;

  assign out_status        = status_r;
  assign out_frame_class   = class_r;
  assign out_dest_mac      = dmac_r;
  assign out_src_mac       = smac_r;
  assign out_src_ip        = sip_r;
  assign out_dest_ip       = dip_r;
  assign out_ip_protocol   = proto_r;
  assign out_src_port      = sport_r;
  assign out_dest_port     = dport_r;
  assign out_tcp_flag_bits = flags_r;
  assign out_tcp_sequence  = seq_r;
  assign out_payload_len   = pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      class_r  <= head_rec.frame_class;
      dmac_r   <= head_rec.dest_mac;
      smac_r   <= head_rec.src_mac;
      sip_r    <= is_ip ? head_rec.src_ip : 32'd0;
      dip_r    <= is_ip ? head_rec.dest_ip : 32'd0;
      proto_r  <= is_ip ? head_rec.protocol : 8'd0;
      sport_r  <= ports ? head_rec.src_port : 16'd0;
      dport_r  <= ports ? head_rec.dest_port : 16'd0;
      flags_r  <= tcp ? head_rec.tcp_flags : 8'd0;
      seq_r    <= tcp ? head_rec.tcp_sequence : 32'd0;
      pay_r    <= pay;
    end
  end

  a_err_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_status != ST_OK) |-> (out_payload_len == 16'd0
      && out_src_port == 16'd0 && out_dest_port == 16'd0))
    else $error("failed frame carries L4 fields");

  a_flags_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_tcp_flag_bits != 8'd0) |-> (out_ip_protocol == PROTO_TCP
      && out_frame_class == CLS_IPV4))
    else $error("TCP flags on a non-TCP record");

  a_ip_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_frame_class != CLS_IPV4) |-> (out_src_ip == 32'd0
      && out_dest_ip == 32'd0 && out_ip_protocol == 8'd0))
    else $error("IP fields on a non-IPv4 record");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && !$past(pop)))
    else $error("output register reloaded while stalled");

endmodule

@@ rtl/eth_ipv4_l4_header_parser_core.sv @@
// Top level of the Ethernet/IPv4/TCP/UDP header parser.
//
// Usage:
//   Input channel (in_*): one captured frame byte per request, in wire order,
//   with in_last_byte set on the final byte. A request is taken at a rising
//   edge with in_valid high and in_stall low. Bytes go in one per cycle while
//   in_stall is low; it rises only when the two-entry record queue is full.
//   Result channel (out_*): one record per frame, taken at an edge with
//   out_valid high and out_stall low.
// Path: a frame's record goes from front capture into the queue when its last
//   byte is taken, then through the back check into the output register.
// Throughput: one byte per cycle while in_stall is low; back-to-back
//   single-byte frames still flow at one per cycle as long as out_stall stays
//   low, since the back stage pops one record per cycle from the queue.
// Stall: while out_stall is high the output register holds its record; the
//   queue soaks up two more finished frames, after which in_stall holds the
//   byte stream until a record is taken.
// Reset (rst_n low, synchronous): clears the byte counter, all capture
//   registers, the queue and the output valid.
module eth_ipv4_l4_header_parser_core import ehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_frame_class,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_src_mac,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dest_ip,
  output logic [7:0]  out_ip_protocol,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dest_port,
  output logic [7:0]  out_tcp_flag_bits,
  output logic [31:0] out_tcp_sequence,
  output logic [15:0] out_payload_len
);

  logic        push;
  logic        pop;
  frame_rec_t  push_rec;
  frame_rec_t  head_rec;
  queue_stat_t q_stat;

  // front: per-byte capture, emits a record on the last byte
  ehp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  // decouples the byte stream from the result handshake
  ehp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  // back: header validity checks, payload length, output register
  ehp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_rec           (head_rec),
    .q_stat             (q_stat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_frame_class    (out_frame_class),
    .out_dest_mac       (out_dest_mac),
    .out_src_mac        (out_src_mac),
    .out_src_ip         (out_src_ip),
    .out_dest_ip        (out_dest_ip),
    .out_ip_protocol    (out_ip_protocol),
    .out_src_port       (out_src_port),
    .out_dest_port      (out_dest_port),
    .out_tcp_flag_bits  (out_tcp_flag_bits),
    .out_tcp_sequence   (out_tcp_sequence),
    .out_payload_len    (out_payload_len)
  );

endmodule
